/* rtl/eqf_pkg.sv */
package eqf_pkg;

  localparam int unsigned NCols    = 8;
  localparam int unsigned RowW     = 3;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned DiagW    = 15;
  localparam int unsigned SolNumW  = 7;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  typedef logic [RowW-1:0] row_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // start a new search from the input item
    logic step;       // advance the search by one move
    logic emit;       // copy the held solution into the output register
    logic emit_last;  // mark the emitted solution as the final one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_solution;  // all eight columns are placed
    logic exhausted;    // this step backtracks past the first column
    logic hold_valid;   // a solution waits in the hold register
  } sts_t;

endpackage

/* rtl/eight_queens_fixed_queen_enumerator_core.sv */
// Eight queens enumerator with one fixed queen.
//
// Input channel (in_*): one item carries the square of a pre-placed queen.
// The block then lists every placement of eight non-attacking queens that
// contains it, one result item per solution, in ascending order of the
// column-by-column row tuple. Each result carries a 1-based solution number;
// out_tlast marks the final solution of the search.
//
// Throughput: a backtracking search that makes one move per cycle (place a
// queen, skip the fixed column, or step back to the previous non-fixed
// column), except that it waits at a solution while the output is full;
// in_tready is high only between searches. Each solution leaves one solution
// later than it is found, since the last marker is known only at the end;
// the final one is emitted once the search runs out and the output has room.
//
// A stalled receiver stops the search on the next solution found; the search
// moves on as soon as the output register frees up. Synchronous active-low
// reset clears the controller and the output valid; no search is pending.
module eight_queens_fixed_queen_enumerator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // fixed_row[2:0], fixed_col[5:3], zero[7:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // solution_number[6:0], row_in_col0..7 3 bits each
                                  // [9:7]..[30:28], zero[31]
  output logic        out_tlast   // last_solution
);

  eqf_pkg::cmd_t                       cmd;
  eqf_pkg::sts_t                       sts;
  logic [eqf_pkg::SolNumW-1:0]         out_num;
  eqf_pkg::row_t [eqf_pkg::NCols-1:0]  out_rows;
  logic                                unused_in;

  assign unused_in = ^in_tdata[7:6];

  eqf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  eqf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .fixed_row (in_tdata[2:0]),
    .fixed_col (in_tdata[5:3]),
    .cmd       (cmd),
    .sts       (sts),
    .out_num   (out_num),
    .out_rows  (out_rows),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_rows, out_num};

`ifndef SYNTHESIS
  a_emit_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.hold_valid)
    else $error("emit without a held solution");

  a_load_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!cmd.step && !cmd.emit))
    else $error("load overlaps a search command");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again while searching");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && out_tvalid) |-> out_tready)
    else $error("output overwritten while stalled");
`endif

endmodule

/* rtl/eqf_ctrl.sv */
module eqf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  eqf_pkg::sts_t sts,
  output eqf_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_push;

  assign can_push = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.at_solution) begin
          // a new solution pushes the held one out first; hold if the output is full
          if (!sts.hold_valid || can_push) begin
            cmd.step = 1'b1;
            cmd.emit = sts.hold_valid;
          end
        end else begin
          cmd.step = 1'b1;
          if (sts.exhausted) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!sts.hold_valid) begin
          state_nxt = ST_IDLE;
        end else if (can_push) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/eqf_dp.sv */
module eqf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  eqf_pkg::row_t                       fixed_row,
  input  eqf_pkg::row_t                       fixed_col,
  input  eqf_pkg::cmd_t                       cmd,
  output eqf_pkg::sts_t                       sts,
  output logic [eqf_pkg::SolNumW-1:0]         out_num,
  output eqf_pkg::row_t [eqf_pkg::NCols-1:0]  out_rows,
  output logic                                out_last
);

  logic [eqf_pkg::NCols-1:0]   rows_r, rows_nxt;
  logic [eqf_pkg::DiagW-1:0]   main_r, main_nxt;
  logic [eqf_pkg::DiagW-1:0]   anti_r, anti_nxt;
  logic [eqf_pkg::LevelW-1:0]  level_r, level_nxt;
  logic [eqf_pkg::LevelW-1:0]  start_r, start_nxt;
  eqf_pkg::row_t               pin_col_r;
  eqf_pkg::row_t               stk_r  [eqf_pkg::NCols];
  eqf_pkg::row_t               hold_r [eqf_pkg::NCols];
  logic                        hold_valid_r;
  logic [eqf_pkg::SolNumW-1:0] cnt_r;

  eqf_pkg::row_t               col, pick, pc, pr;
  logic                        at_sol, at_pin, found, bt_end, place;
  logic [eqf_pkg::NCols-1:0]   main_col, anti_col, free;
  logic [eqf_pkg::LevelW-1:0]  prev_a, prev;
  logic [eqf_pkg::LevelW-1:0]  m_set, a_set, m_clr, a_clr;

  assign col    = level_r[eqf_pkg::RowW-1:0];
  assign at_sol = level_r[eqf_pkg::LevelW-1];
  assign at_pin = !at_sol && (col == pin_col_r);

  // diagonals seen from the current column, indexed by row
  assign main_col = eqf_pkg::NCols'(main_r >> (3'd7 - col));
  assign anti_col = eqf_pkg::NCols'(anti_r >> col);
  assign free     = ~(rows_r | main_col | anti_col) & (8'hFF << start_r);

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = eqf_pkg::NCols - 1; i >= 0; i--) begin
      if (free[i]) begin
        found = 1'b1;
        pick  = eqf_pkg::row_t'(i);
      end
    end
  end

  // backtrack target: previous column, skipping the fixed one
  always_comb begin
    prev_a = level_r - 4'd1;
    prev   = prev_a;
    bt_end = (level_r == '0);
    if (!bt_end && (prev_a[eqf_pkg::RowW-1:0] == pin_col_r)) begin
      if (prev_a == '0) begin
        bt_end = 1'b1;
      end else begin
        prev = prev_a - 4'd1;
      end
    end
  end

  assign pc    = prev[eqf_pkg::RowW-1:0];
  assign pr    = stk_r[pc];
  assign place = !at_sol && !at_pin && found;

  assign m_set = {1'b0, pick} + 4'd7 - {1'b0, col};
  assign a_set = {1'b0, pick} + {1'b0, col};
  assign m_clr = {1'b0, pr} + 4'd7 - {1'b0, pc};
  assign a_clr = {1'b0, pr} + {1'b0, pc};

  always_comb begin
    rows_nxt  = rows_r;
    main_nxt  = main_r;
    anti_nxt  = anti_r;
    level_nxt = level_r;
    start_nxt = start_r;
    if (cmd.load) begin
      rows_nxt  = eqf_pkg::NCols'(1) << fixed_row;
      main_nxt  = eqf_pkg::DiagW'(1) << ({1'b0, fixed_row} + 4'd7 - {1'b0, fixed_col});
      anti_nxt  = eqf_pkg::DiagW'(1) << ({1'b0, fixed_row} + {1'b0, fixed_col});
      level_nxt = '0;
      start_nxt = '0;
    end else if (cmd.step) begin
      if (at_pin) begin
        level_nxt = level_r + 4'd1;
        start_nxt = '0;
      end else if (place) begin
        rows_nxt  = rows_r | (eqf_pkg::NCols'(1) << pick);
        main_nxt  = main_r | (eqf_pkg::DiagW'(1) << m_set);
        anti_nxt  = anti_r | (eqf_pkg::DiagW'(1) << a_set);
        level_nxt = level_r + 4'd1;
        start_nxt = '0;
      end else if (!bt_end) begin
        // drop the queen of the previous column and resume above it
        rows_nxt  = rows_r & ~(eqf_pkg::NCols'(1) << pr);
        main_nxt  = main_r & ~(eqf_pkg::DiagW'(1) << m_clr);
        anti_nxt  = anti_r & ~(eqf_pkg::DiagW'(1) << a_clr);
        level_nxt = prev;
        start_nxt = {1'b0, pr} + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= '0;
      main_r       <= '0;
      anti_r       <= '0;
      level_r      <= '0;
      start_r      <= '0;
      hold_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      rows_r  <= rows_nxt;
      main_r  <= main_nxt;
      anti_r  <= anti_nxt;
      level_r <= level_nxt;
      start_r <= start_nxt;
      if (cmd.load) begin
        hold_valid_r <= 1'b0;
        cnt_r        <= '0;
      end else if (cmd.step && at_sol) begin
        hold_valid_r <= 1'b1;
        cnt_r        <= cnt_r + 7'd1;
      end else if (cmd.emit && cmd.emit_last) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pin_col_r        <= fixed_col;
      stk_r[fixed_col] <= fixed_row;
    end else if (cmd.step && place) begin
      stk_r[col] <= pick;
    end
    if (cmd.step && at_sol) begin
      for (int i = 0; i < eqf_pkg::NCols; i++) begin
        hold_r[i] <= stk_r[i];
      end
    end
    if (cmd.emit) begin
      out_num  <= cnt_r;
      out_last <= cmd.emit_last;
      for (int i = 0; i < eqf_pkg::NCols; i++) begin
        out_rows[i] <= hold_r[i];
      end
    end
  end

  assign sts.at_solution = at_sol;
  assign sts.exhausted   = !at_sol && !at_pin && !found && bt_end;
  assign sts.hold_valid  = hold_valid_r;

endmodule

/* sim/eight_queens_fixed_queen_enumerator_core_tb.sv */
`timescale 1ns / 1ps

module eight_queens_fixed_queen_enumerator_core_tb;

  localparam int BoardSize   = eqf_pkg::NCols;
  localparam int QuietLimit  = 20000;
  localparam int LongHold    = 3000;
  localparam int SettleCycles = 20;

  typedef struct packed {
    logic [eqf_pkg::SolNumW-1:0]                 number;
    logic [eqf_pkg::NCols-1:0][eqf_pkg::RowW-1:0] rows;
    logic                                        last;
  } placement_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [eqf_pkg::InDataW-1:0]  in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [eqf_pkg::OutDataW-1:0] out_tdata;
  logic                         out_tlast;

  placement_t pending_solutions [$];
  int         error_count;
  int         sender_idle_pct;
  int         receiver_idle_pct;
  int         hold_request;
  int         hold_left;
  int         quiet_cycles;

  eight_queens_fixed_queen_enumerator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Backtracking search over columns, rows tried in ascending order.
  function automatic void enumerate_placements(eqf_pkg::row_t pin_row,
                                               eqf_pkg::row_t pin_col);
    logic [BoardSize-1:0]                         rows_busy;
    logic [eqf_pkg::DiagW-1:0]                    diag_busy;
    logic [eqf_pkg::DiagW-1:0]                    anti_busy;
    logic [eqf_pkg::NCols-1:0][eqf_pkg::RowW-1:0] placed;
    int                                           next_try [BoardSize+1];
    placement_t                                   found [$];
    placement_t                                   entry;
    int                                           col;
    int                                           r;
    int                                           i;
    bit                                           retreat;
    bit                                           hit;
    rows_busy = '0;
    diag_busy = '0;
    anti_busy = '0;
    placed    = '0;
    rows_busy[int'(pin_row)] = 1'b1;
    diag_busy[int'(pin_row) + 7 - int'(pin_col)] = 1'b1;
    anti_busy[int'(pin_row) + int'(pin_col)] = 1'b1;
    col = 0;
    next_try[0] = 0;
    retreat = 1'b0;
    while (col >= 0) begin
      if (col == BoardSize) begin
        entry.number = eqf_pkg::SolNumW'(found.size() + 1);
        entry.rows   = placed;
        entry.last   = 1'b0;
        found = {found, entry};
        col = col - 1;
        retreat = 1'b1;
      end else if (col == int'(pin_col)) begin
        if (retreat) begin
          col = col - 1;
        end else begin
          placed[col] = pin_row;
          col = col + 1;
          next_try[col] = 0;
        end
      end else begin
        if (retreat) begin
          // release the queen of this column before trying the next row
          r = int'(placed[col]);
          rows_busy[r] = 1'b0;
          diag_busy[r + 7 - col] = 1'b0;
          anti_busy[r + col] = 1'b0;
          retreat = 1'b0;
        end
        hit = 1'b0;
        r = next_try[col];
        while (!hit && r < BoardSize) begin
          if (!rows_busy[r] && !diag_busy[r + 7 - col] && !anti_busy[r + col])
            hit = 1'b1;
          else
            r = r + 1;
        end
        if (hit) begin
          rows_busy[r] = 1'b1;
          diag_busy[r + 7 - col] = 1'b1;
          anti_busy[r + col] = 1'b1;
          placed[col] = eqf_pkg::row_t'(r);
          next_try[col] = r + 1;
          col = col + 1;
          next_try[col] = 0;
        end else begin
          col = col - 1;
          retreat = 1'b1;
        end
      end
    end
    for (i = 0; i < found.size(); i++) begin
      entry = found[i];
      entry.last = (i == found.size() - 1);
      pending_solutions = {pending_solutions, entry};
    end
  endfunction

  task automatic check_solution_item();
    placement_t want;
    int         j;
    if (pending_solutions.size() == 0) begin
      $error("unexpected result item: tdata=%h tlast=%b", out_tdata, out_tlast);
      error_count++;
    end else begin
      want = pending_solutions.pop_front();
      if (out_tdata[eqf_pkg::SolNumW-1:0] !== want.number) begin
        $error("solution_number: expected %0d, got %0d", want.number,
               out_tdata[eqf_pkg::SolNumW-1:0]);
        error_count++;
      end
      for (j = 0; j < BoardSize; j++) begin
        if (out_tdata[eqf_pkg::SolNumW + eqf_pkg::RowW*j +: eqf_pkg::RowW]
            !== want.rows[j]) begin
          $error("row_in_col%0d: expected %0d, got %0d", j, want.rows[j],
                 out_tdata[eqf_pkg::SolNumW + eqf_pkg::RowW*j +: eqf_pkg::RowW]);
          error_count++;
        end
      end
      if (out_tlast !== want.last) begin
        $error("last_solution: expected %0b, got %0b", want.last, out_tlast);
        error_count++;
      end
    end
  endtask

  // Predict on accepted input first, then check accepted output.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        enumerate_placements(eqf_pkg::row_t'(in_tdata[2:0]),
                             eqf_pkg::row_t'(in_tdata[5:3]));
      if (out_tvalid && out_tready)
        check_solution_item();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold when one is requested.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Leave valid high after acceptance so back-to-back items need no gap.
  task automatic send_square(eqf_pkg::row_t row, eqf_pkg::row_t col);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, col, row};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_for_solutions();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_squares();
    int i;
    for (i = 0; i < BoardSize; i++)
      send_square(eqf_pkg::row_t'(i), eqf_pkg::row_t'(i));
    for (i = 0; i < BoardSize; i++)
      send_square(eqf_pkg::row_t'(i), eqf_pkg::row_t'(BoardSize - 1 - i));
    wait_for_solutions();
  endtask

  task automatic test_random_squares(int count, int send_idle, int recv_idle);
    int n;
    sender_idle_pct   = send_idle;
    receiver_idle_pct = recv_idle;
    for (n = 0; n < count; n++)
      send_square(eqf_pkg::row_t'($urandom_range(7)), eqf_pkg::row_t'($urandom_range(7)));
    wait_for_solutions();
  endtask

  // Hold the output off while several searches queue up behind it.
  task automatic test_output_backpressure();
    int n;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_request      = LongHold;
    for (n = 0; n < 4; n++)
      send_square(eqf_pkg::row_t'($urandom_range(7)), eqf_pkg::row_t'($urandom_range(7)));
    wait_for_solutions();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    error_count       = 0;
    sender_idle_pct   = 35;
    receiver_idle_pct = 56;
    hold_request      = 0;
    quiet_cycles      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_squares();
    test_random_squares(90, 35, 56);
    test_random_squares(90, 56, 35);
    test_random_squares(90, 0, 0);
    test_output_backpressure();

    repeat (SettleCycles) @(posedge clk);
    if (pending_solutions.size() != 0) begin
      $error("%0d expected results never arrived", pending_solutions.size());
      error_count++;
    end
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* eight_queens_fixed_queen_enumerator_core.f */
rtl/eqf_pkg.sv
rtl/eqf_ctrl.sv
rtl/eqf_dp.sv
rtl/eight_queens_fixed_queen_enumerator_core.sv
sim/eight_queens_fixed_queen_enumerator_core_tb.sv
